// ===== design/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg
// Types, codes and helpers shared by the sensor compensation block.
// ----------------------------------------------------------------------------
package esc_pkg;

  // disabled-measurement markers
  localparam logic [23:0] OFF_MARK_TP = 24'h800000;
  localparam logic [15:0] OFF_MARK_H  = 16'h8000;

  // serial multiplier: digit width and digits per 64-bit operand
  localparam int DIGIT_W    = 4;
  localparam int MUL_DIGITS = 64 / DIGIT_W;
  localparam int DIV_BITS   = 64;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP  = 3'd0,
    CFG_PA    = 3'd1,
    CFG_PB    = 3'd2,
    CFG_PC    = 3'd3,
    CFG_HA    = 3'd4,
    CFG_HB    = 3'd5,
    CFG_OFS   = 3'd6
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_MUL,
    S_POST,
    S_DIVSET,
    S_DIV,
    S_OUT
  } state_t;

  // micro-program steps
  typedef enum logic [4:0] {
    ST_T0, ST_T1, ST_T2,
    ST_P0, ST_P1, ST_P2, ST_P3, ST_P4, ST_P5, ST_P6,
    ST_DIV,
    ST_P7, ST_P8, ST_P9, ST_PF,
    ST_H0, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7,
    ST_FIN
  } step_t;

  function automatic logic [63:0] sx32(input logic [31:0] x);
    return {{32{x[31]}}, x};
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] x);
    return {{48{x[15]}}, x};
  endfunction

  // state that runs a given step
  function automatic state_t step_state(input step_t s);
    state_t r;
    case (s)
      ST_FIN:  r = S_OUT;
      ST_DIV:  r = S_DIVSET;
      ST_PF:   r = S_POST;
      default: r = S_SETUP;
    endcase
    return r;
  endfunction

endpackage

// ===== design/esc_in_if.sv =====
// ----------------------------------------------------------------------------
// esc_in_if
// Raw reading channel: one item holds the three raw data words.
// ----------------------------------------------------------------------------
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] raw_temperature;
  logic [23:0] raw_pressure;
  logic [15:0] raw_humidity;

  modport source (output valid, raw_temperature, raw_pressure, raw_humidity,
                  input ready);
  modport sink   (input valid, raw_temperature, raw_pressure, raw_humidity,
                  output ready);
endinterface

// ===== design/esc_out_if.sv =====
// ----------------------------------------------------------------------------
// esc_out_if
// Result channel: compensated values and their flags.
// ----------------------------------------------------------------------------
interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [26:0] temperature_centi;
  logic        temperature_ok;
  logic [31:0] pressure_q24_8;
  logic        pressure_ok;
  logic        pressure_div_zero;
  logic [16:0] humidity_q22_10;
  logic        humidity_ok;

  modport source (output valid, temperature_centi, temperature_ok, pressure_q24_8,
                  pressure_ok, pressure_div_zero, humidity_q22_10, humidity_ok,
                  input ready);
  modport sink   (input valid, temperature_centi, temperature_ok, pressure_q24_8,
                  pressure_ok, pressure_div_zero, humidity_q22_10, humidity_ok,
                  output ready);
endinterface

// ===== design/esc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// esc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface esc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/env_sensor_compensation.sv =====
// Each multiply step runs setup, the digit-serial multiply and post; an item
// with all three readings enabled takes up to 21 multiply steps plus a serial
// division and one final step.
// Throughput: one item at a time; the next is taken after the result is taken.
// The shared 4-bit-digit serial multiplier sets the rate.
// Reset (synchronous, rst_n low) clears calibration, fine temperature, state.
// ----------------------------------------------------------------------------
// env_sensor_compensation
// Integer temperature, pressure and humidity compensation on a micro-sequenced
// digit-serial multiplier and bit-serial divider.
// ----------------------------------------------------------------------------
module env_sensor_compensation (
  input  logic       clk,
  input  logic       rst_n,
  esc_in_if.sink     in_chan,
  esc_out_if.source  out_chan,
  esc_cfg_if.sink    cfg_chan
);
  import esc_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  logic [47:0] temp_cal_r, pa_cal_r, pb_cal_r, pc_cal_r;
  logic [39:0] ha_cal_r;
  logic [23:0] hb_cal_r;
  logic [31:0] ofs_r;
  logic [31:0] ft_r, ft_nxt;

  logic [23:0] raw_t_r, raw_p_r;
  logic [15:0] raw_h_r;

  logic [63:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt, rd_r, rd_nxt;
  logic [63:0] mul_a_r, mul_b_r, acc_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, dq_r, dvs_r;
  logic        neg_r;

  logic        t_ok_r, p_ok_r, h_ok_r, dz_r, dz_nxt;
  logic [31:0] press_r, press_nxt;
  logic [16:0] hum_r, hum_nxt;

  logic        in_acc, out_acc;
  logic        t_en, p_en, h_en, t_en_in, p_en_in, h_en_in;
  step_t       after_t, after_p, start_step;

  // calibration fields
  logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [63:0] h1, h2, h3, h4, h5, h6;

  assign t1 = {48'd0, temp_cal_r[15:0]};
  assign t2 = sx16(temp_cal_r[31:16]);
  assign t3 = sx16(temp_cal_r[47:32]);
  assign p1 = {48'd0, pa_cal_r[15:0]};
  assign p2 = sx16(pa_cal_r[31:16]);
  assign p3 = sx16(pa_cal_r[47:32]);
  assign p4 = sx16(pb_cal_r[15:0]);
  assign p5 = sx16(pb_cal_r[31:16]);
  assign p6 = sx16(pb_cal_r[47:32]);
  assign p7 = sx16(pc_cal_r[15:0]);
  assign p8 = sx16(pc_cal_r[31:16]);
  assign p9 = sx16(pc_cal_r[47:32]);
  assign h1 = {56'd0, ha_cal_r[7:0]};
  assign h2 = sx16(ha_cal_r[23:8]);
  assign h3 = {56'd0, ha_cal_r[31:24]};
  assign h6 = {{56{ha_cal_r[39]}}, ha_cal_r[39:32]};
  assign h4 = {{52{hb_cal_r[11]}}, hb_cal_r[11:0]};
  assign h5 = {{52{hb_cal_r[23]}}, hb_cal_r[23:12]};

  // handshakes
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;
  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // which measurements run
  assign t_en_in = (in_chan.raw_temperature != OFF_MARK_TP);
  assign p_en_in = (in_chan.raw_pressure != OFF_MARK_TP);
  assign h_en_in = (in_chan.raw_humidity != OFF_MARK_H);
  assign t_en    = (state_r == S_IDLE) ? t_en_in : (raw_t_r != OFF_MARK_TP);
  assign p_en    = (state_r == S_IDLE) ? p_en_in : (raw_p_r != OFF_MARK_TP);
  assign h_en    = (state_r == S_IDLE) ? h_en_in : (raw_h_r != OFF_MARK_H);
  assign after_p    = h_en ? ST_H0 : ST_FIN;
  assign after_t    = p_en ? ST_P0 : after_p;
  assign start_step = t_en ? ST_T0 : after_t;

  // shared intermediate values
  logic [63:0] v1p, pp, pa;
  logic [31:0] xh, qh;
  assign v1p = sx32(ft_r) - 64'd128000;
  assign pp  = 64'd1048576 - {44'd0, raw_p_r[23:4]};
  assign pa  = 64'($signed(rb_r) >>> 13);
  assign xh  = ft_r - 32'd76800;
  assign qh  = 32'($signed(rc_r[31:0]) >>> 15);

  // multiplier operand select
  logic [63:0] opa, opb;
  always_comb begin
    opa = 64'd0;
    opb = 64'd0;
    case (step_r)
      ST_T0: begin
        opa = sx32({15'd0, raw_t_r[23:7]} - {15'd0, t1[15:0], 1'b0});
        opb = t2;
      end
      ST_T1: begin
        opa = sx32({16'd0, raw_t_r[23:8]} - {16'd0, t1[15:0]});
        opb = opa;
      end
      ST_T2: begin opa = sx32(rb_r[31:0]); opb = t3; end
      ST_P0: begin opa = v1p; opb = v1p; end
      ST_P1: begin opa = rc_r; opb = p6; end
      ST_P2: begin opa = v1p; opb = p5; end
      ST_P3: begin opa = rc_r; opb = p3; end
      ST_P4: begin opa = v1p; opb = p2; end
      ST_P5: begin opa = 64'h0000_8000_0000_0000 + ra_r; opb = p1; end
      ST_P6: begin opa = {pp[32:0], 31'd0} - rd_r; opb = 64'd3125; end
      ST_P7: begin opa = p9; opb = pa; end
      ST_P8: begin opa = rc_r; opb = pa; end
      ST_P9: begin opa = p8; opb = rb_r; end
      ST_H0: begin opa = h5; opb = sx32(xh); end
      ST_H1: begin opa = sx32(xh); opb = h6; end
      ST_H2: begin opa = sx32(xh); opb = h3; end
      ST_H3: begin opa = sx32(rb_r[31:0]); opb = sx32(rc_r[31:0]); end
      ST_H4: begin opa = sx32(rb_r[31:0]); opb = h2; end
      ST_H5: begin opa = sx32(ra_r[31:0]); opb = sx32(rb_r[31:0]); end
      ST_H6: begin opa = sx32(qh); opb = sx32(qh); end
      ST_H7: begin opa = sx32(rd_r[31:0]); opb = h1; end
      default: begin opa = 64'd0; opb = 64'd0; end
    endcase
  end

  // one digit of partial product
  logic [DIGIT_W-1:0] dig;
  logic [63:0]        part;
  assign dig  = mul_b_r[DIGIT_W-1:0];
  assign part = ({64{dig[0]}} & mul_a_r)
              + ({64{dig[1]}} & {mul_a_r[62:0], 1'b0})
              + ({64{dig[2]}} & {mul_a_r[61:0], 2'b0})
              + ({64{dig[3]}} & {mul_a_r[60:0], 3'b0});

  // one bit of restoring division
  logic [64:0] trial;
  logic        qbit;
  assign trial = {rem_r, dq_r[63]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  // post-processing of each step
  logic [63:0] m;
  logic [31:0] m32, t_v2, h_a, h_x;
  logic [63:0] p_sum, p_fin;
  assign m     = acc_r;
  assign m32   = acc_r[31:0];
  assign t_v2  = 32'($signed(m32) >>> 14);
  assign h_a   = {2'b0, raw_h_r, 14'd0} - {h4[11:0], 20'd0} - m32 + 32'd16384;
  assign h_x   = rc_r[31:0] - 32'($signed(m32) >>> 4);
  assign p_sum = rb_r + rc_r + rd_r;
  assign p_fin = 64'($signed(p_sum) >>> 8) + {p7[59:0], 4'd0};

  always_comb begin
    step_nxt  = step_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    rc_nxt    = rc_r;
    rd_nxt    = rd_r;
    ft_nxt    = ft_r;
    dz_nxt    = dz_r;
    press_nxt = press_r;
    hum_nxt   = hum_r;
    if (state_r == S_POST) begin
      case (step_r)
        ST_T0: begin ra_nxt = sx32(32'($signed(m32) >>> 11)); step_nxt = ST_T1; end
        ST_T1: begin rb_nxt = sx32(32'($signed(m32) >>> 12)); step_nxt = ST_T2; end
        ST_T2: begin
          ft_nxt   = ra_r[31:0] + t_v2 + ofs_r;
          step_nxt = after_t;
        end
        ST_P0: begin rc_nxt = m; step_nxt = ST_P1; end
        ST_P1: begin rd_nxt = m; step_nxt = ST_P2; end
        ST_P2: begin
          rd_nxt   = rd_r + {m[46:0], 17'd0} + {p4[28:0], 35'd0};
          step_nxt = ST_P3;
        end
        ST_P3: begin ra_nxt = 64'($signed(m) >>> 8); step_nxt = ST_P4; end
        ST_P4: begin ra_nxt = ra_r + {m[51:0], 12'd0}; step_nxt = ST_P5; end
        ST_P5: begin
          ra_nxt = 64'($signed(m) >>> 33);
          if (ra_nxt == 64'd0) begin
            dz_nxt   = 1'b1;
            step_nxt = after_p;
          end else begin
            step_nxt = ST_P6;
          end
        end
        ST_P6:  begin rc_nxt = m; step_nxt = ST_DIV; end
        ST_DIV: begin
          rb_nxt   = neg_r ? (64'd0 - dq_r) : dq_r;
          step_nxt = ST_P7;
        end
        ST_P7: begin rc_nxt = m; step_nxt = ST_P8; end
        ST_P8: begin rc_nxt = 64'($signed(m) >>> 25); step_nxt = ST_P9; end
        ST_P9: begin rd_nxt = 64'($signed(m) >>> 19); step_nxt = ST_PF; end
        ST_PF: begin
          if (p_fin[63])
            press_nxt = 32'd0;
          else if (p_fin[62:32] != 31'd0)
            press_nxt = 32'hFFFF_FFFF;
          else
            press_nxt = p_fin[31:0];
          step_nxt = after_p;
        end
        ST_H0: begin ra_nxt = sx32(32'($signed(h_a) >>> 15)); step_nxt = ST_H1; end
        ST_H1: begin rb_nxt = sx32(32'($signed(m32) >>> 10)); step_nxt = ST_H2; end
        ST_H2: begin
          rc_nxt   = sx32(32'($signed(m32) >>> 11) + 32'd32768);
          step_nxt = ST_H3;
        end
        ST_H3: begin
          rb_nxt   = sx32(32'($signed(m32) >>> 10) + 32'd2097152);
          step_nxt = ST_H4;
        end
        ST_H4: begin
          rb_nxt   = sx32(32'($signed(m32 + 32'd8192) >>> 14));
          step_nxt = ST_H5;
        end
        ST_H5: begin rc_nxt = sx32(m32); step_nxt = ST_H6; end
        ST_H6: begin rd_nxt = sx32(32'($signed(m32) >>> 7)); step_nxt = ST_H7; end
        ST_H7: begin
          if (h_x[31])
            hum_nxt = 17'd0;
          else if (h_x > 32'd419430400)
            hum_nxt = 17'd102400;
          else
            hum_nxt = h_x[28:12];
          step_nxt = ST_FIN;
        end
        default: step_nxt = ST_FIN;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_acc) state_nxt = step_state(start_step);
      S_SETUP:  state_nxt = S_MUL;
      S_MUL:    if (cnt_r == 6'(MUL_DIGITS - 1)) state_nxt = S_POST;
      S_POST:   state_nxt = step_state(step_nxt);
      S_DIVSET: state_nxt = S_DIV;
      S_DIV:    if (cnt_r == 6'(DIV_BITS - 1)) state_nxt = S_POST;
      S_OUT:    if (out_acc) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      step_r     <= ST_FIN;
      temp_cal_r <= '0;
      pa_cal_r   <= '0;
      pb_cal_r   <= '0;
      pc_cal_r   <= '0;
      ha_cal_r   <= '0;
      hb_cal_r   <= '0;
      ofs_r      <= '0;
      ft_r       <= '0;
      t_ok_r     <= 1'b0;
      p_ok_r     <= 1'b0;
      h_ok_r     <= 1'b0;
      dz_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ft_r    <= ft_nxt;
      if (in_acc) begin
        step_r <= start_step;
        t_ok_r <= t_en_in;
        p_ok_r <= p_en_in;
        h_ok_r <= h_en_in;
        dz_r   <= 1'b0;
      end else begin
        step_r <= step_nxt;
        dz_r   <= dz_nxt;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          CFG_TEMP: temp_cal_r <= cfg_chan.data;
          CFG_PA:   pa_cal_r   <= cfg_chan.data;
          CFG_PB:   pb_cal_r   <= cfg_chan.data;
          CFG_PC:   pc_cal_r   <= cfg_chan.data;
          CFG_HA:   ha_cal_r   <= cfg_chan.data[39:0];
          CFG_HB:   hb_cal_r   <= cfg_chan.data[23:0];
          CFG_OFS:  ofs_r      <= cfg_chan.data[31:0];
          default:  ;
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    ra_r <= ra_nxt;
    rb_r <= rb_nxt;
    rc_r <= rc_nxt;
    rd_r <= rd_nxt;
    if (in_acc) begin
      raw_t_r <= in_chan.raw_temperature;
      raw_p_r <= in_chan.raw_pressure;
      raw_h_r <= in_chan.raw_humidity;
      press_r <= 32'd0;
      hum_r   <= 17'd0;
    end else begin
      press_r <= press_nxt;
      hum_r   <= hum_nxt;
    end
    case (state_r)
      S_SETUP: begin
        mul_a_r <= opa;
        mul_b_r <= opb;
        acc_r   <= 64'd0;
        cnt_r   <= 6'd0;
      end
      S_MUL: begin
        acc_r   <= acc_r + part;
        mul_a_r <= {mul_a_r[63-DIGIT_W:0], {DIGIT_W{1'b0}}};
        mul_b_r <= {{DIGIT_W{1'b0}}, mul_b_r[63:DIGIT_W]};
        cnt_r   <= cnt_r + 6'd1;
      end
      S_DIVSET: begin
        rem_r <= 64'd0;
        dq_r  <= rc_r[63] ? (64'd0 - rc_r) : rc_r;
        dvs_r <= ra_r[63] ? (64'd0 - ra_r) : ra_r;
        neg_r <= rc_r[63] ^ ra_r[63];
        cnt_r <= 6'd0;
      end
      S_DIV: begin
        rem_r <= qbit ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];
        dq_r  <= {dq_r[62:0], qbit};
        cnt_r <= cnt_r + 6'd1;
      end
      default: ;
    endcase
  end

  // result fields
  logic [31:0] tc_full;
  assign tc_full = 32'($signed({ft_r[29:0], 2'b0} + ft_r + 32'd128) >>> 8);

  always_comb begin
    out_chan.valid             = (state_r == S_OUT);
    out_chan.temperature_centi = t_ok_r ? tc_full[26:0] : 27'd0;
    out_chan.temperature_ok    = t_ok_r;
    out_chan.pressure_q24_8    = p_ok_r ? press_r : 32'd0;
    out_chan.pressure_ok       = p_ok_r;
    out_chan.pressure_div_zero = p_ok_r && dz_r;
    out_chan.humidity_q22_10   = h_ok_r ? hum_r : 17'd0;
    out_chan.humidity_ok       = h_ok_r;
  end

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_chan.valid && in_chan.ready))
    else $error("result shown while input side open");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_chan.ready)
    else $error("input still open after accept");

  a_free_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |=> in_chan.ready)
    else $error("block not idle after result taken");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.pressure_div_zero) |->
      (out_chan.pressure_q24_8 == 32'd0 && out_chan.pressure_ok))
    else $error("zero divisor with non-zero pressure");

endmodule

// ===== tb/sv/tb_env_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_env_sensor_compensation
// Self-checking bench for the sensor compensation block: calibration phases
// are written over the register port while the block is idle, raw reading
// items are streamed in with random gaps and compared against an in-bench
// integer compensation predictor.
// ----------------------------------------------------------------------------
module tb_env_sensor_compensation;
  import esc_pkg::*;

  localparam int          CYCLE_LIMIT = 4000000;
  localparam int          SETTLE      = 600;
  localparam logic [2:0]  CFG_UNUSED  = 3'd7;

  typedef struct packed {
    logic [23:0] rt;
    logic [23:0] rp;
    logic [15:0] rh;
  } reading_t;

  typedef struct packed {
    logic [26:0] tcent;
    logic        t_ok;
    logic [31:0] press;
    logic        p_ok;
    logic        p_dz;
    logic [16:0] hum;
    logic        h_ok;
  } comp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  esc_in_if  in_chan ();
  esc_out_if out_chan ();
  esc_cfg_if cfg_chan ();

  env_sensor_compensation uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  always #5 clk = ~clk;

  // predictor copy of calibration and state
  logic [47:0] cal_t, cal_pa, cal_pb, cal_pc;
  logic [39:0] cal_ha;
  logic [23:0] cal_hb;
  int          cal_ofs;
  int          fine_t;

  reading_t pending_readings[$];
  comp_t    expected_comp[$];
  int       errors = 0;
  int       cycles = 0;
  bit       calm   = 0;

  // compensation of one reading set; updates the fine temperature
  function automatic comp_t compensate(input reading_t r);
    comp_t  c;
    int     adc, t1, t2, t3, tv1, tv2, d, tc;
    longint p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, p, pa, num;
    int     h1, h2, h3, h4, h5, h6, x, a, b, q;
    c = '0;
    if (r.rt != OFF_MARK_TP) begin
      adc = {12'b0, r.rt[23:4]};
      t1  = {16'b0, cal_t[15:0]};
      t2  = $signed(cal_t[31:16]);
      t3  = $signed(cal_t[47:32]);
      tv1 = (((adc >>> 3) - (t1 <<< 1)) * t2) >>> 11;
      d   = (adc >>> 4) - t1;
      tv2 = (((d * d) >>> 12) * t3) >>> 14;
      fine_t = tv1 + tv2 + cal_ofs;
      tc  = (fine_t * 5 + 128) >>> 8;
      c.tcent = tc[26:0];
      c.t_ok  = 1'b1;
    end
    if (r.rp != OFF_MARK_TP) begin
      p1 = {48'b0, cal_pa[15:0]};
      p2 = $signed(cal_pa[31:16]);
      p3 = $signed(cal_pa[47:32]);
      p4 = $signed(cal_pb[15:0]);
      p5 = $signed(cal_pb[31:16]);
      p6 = $signed(cal_pb[47:32]);
      p7 = $signed(cal_pc[15:0]);
      p8 = $signed(cal_pc[31:16]);
      p9 = $signed(cal_pc[47:32]);
      v1 = longint'(fine_t) - 128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      c.p_ok = 1'b1;
      if (v1 == 0) begin
        c.p_dz = 1'b1;
      end else begin
        p   = 64'sd1048576 - longint'({44'b0, r.rp[23:4]});
        num = ((p <<< 31) - v2) * 3125;
        // truncating division, the most negative dividend over -1 wraps
        if (v1 == -1) p = -num;
        else p = num / v1;
        pa = p >>> 13;
        v1 = (p9 * pa * pa) >>> 25;
        v2 = (p8 * p) >>> 19;
        p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
        if (p < 0) c.press = '0;
        else if (p > 64'sh00000000FFFFFFFF) c.press = '1;
        else c.press = p[31:0];
      end
    end
    if (r.rh != OFF_MARK_H) begin
      h1 = {24'b0, cal_ha[7:0]};
      h2 = $signed(cal_ha[23:8]);
      h3 = {24'b0, cal_ha[31:24]};
      h6 = $signed(cal_ha[39:32]);
      h4 = $signed(cal_hb[11:0]);
      h5 = $signed(cal_hb[23:12]);
      x  = fine_t - 76800;
      a  = (({16'b0, r.rh} <<< 14) - (h4 <<< 20)) - (h5 * x);
      a  = (a + 16384) >>> 15;
      b  = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32768);
      b  = (b >>> 10) + 2097152;
      b  = ((b * h2) + 8192) >>> 14;
      x  = a * b;
      q  = x >>> 15;
      x  = x - ((((q * q) >>> 7) * h1) >>> 4);
      if (x < 0) x = 0;
      if (x > 419430400) x = 419430400;
      x  = x >>> 12;
      c.hum  = x[16:0];
      c.h_ok = 1'b1;
    end
    return c;
  endfunction

  // item driver
  reading_t cur;
  int       in_gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.raw_temperature <= '0;
      in_chan.raw_pressure <= '0;
      in_chan.raw_humidity <= '0;
      in_gap = 0;
    end else begin
      if (in_chan.valid && in_chan.ready)
        expected_comp.push_back(compensate(cur));
      if (!in_chan.valid || in_chan.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_chan.valid <= 1'b0;
        end else if (pending_readings.size() > 0) begin
          cur = pending_readings.pop_front();
          in_chan.raw_temperature <= cur.rt;
          in_chan.raw_pressure <= cur.rp;
          in_chan.raw_humidity <= cur.rh;
          in_chan.valid <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 13);
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // result monitor with random back-pressure
  int    out_gap;
  comp_t want;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (expected_comp.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual t=%h p=%h h=%h", $time,
                   out_chan.temperature_centi, out_chan.pressure_q24_8,
                   out_chan.humidity_q22_10);
        end else begin
          want = expected_comp.pop_front();
          check_field("temperature_centi", 32'(want.tcent),
                      32'(out_chan.temperature_centi));
          check_field("temperature_ok", 32'(want.t_ok), 32'(out_chan.temperature_ok));
          check_field("pressure_q24_8", want.press, out_chan.pressure_q24_8);
          check_field("pressure_ok", 32'(want.p_ok), 32'(out_chan.pressure_ok));
          check_field("pressure_div_zero", 32'(want.p_dz),
                      32'(out_chan.pressure_div_zero));
          check_field("humidity_q22_10", 32'(want.hum), 32'(out_chan.humidity_q22_10));
          check_field("humidity_ok", 32'(want.h_ok), 32'(out_chan.humidity_ok));
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!calm && $urandom_range(0, 5) == 0) out_gap = $urandom_range(1, 13);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    @(posedge clk);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= val;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    case (idx)
      CFG_TEMP: cal_t   = val;
      CFG_PA:   cal_pa  = val;
      CFG_PB:   cal_pb  = val;
      CFG_PC:   cal_pc  = val;
      CFG_HA:   cal_ha  = val[39:0];
      CFG_HB:   cal_hb  = val[23:0];
      CFG_OFS:  cal_ofs = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_calib(input logic [47:0] t, pa, pb, pc, ha, hb, ofs);
    write_reg(CFG_TEMP, t);
    write_reg(CFG_PA, pa);
    write_reg(CFG_PB, pb);
    write_reg(CFG_PC, pc);
    write_reg(CFG_HA, ha);
    write_reg(CFG_HB, hb);
    write_reg(CFG_OFS, ofs);
  endtask

  task automatic wait_idle();
    while (pending_readings.size() > 0 || in_chan.valid || expected_comp.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [47:0] rnd48();
    return 48'({$urandom, $urandom});
  endfunction

  // random reading: mostly plausible words, some raw noise and disabled markers
  function automatic reading_t rnd_reading();
    reading_t r;
    r.rt = 24'($urandom_range(24'h680000, 24'h900000));
    r.rp = 24'($urandom_range(24'h300000, 24'h700000));
    r.rh = 16'($urandom_range(16'h4000, 16'h9000));
    if ($urandom_range(0, 5) == 0) r.rt = 24'($urandom);
    if ($urandom_range(0, 5) == 0) r.rp = 24'($urandom);
    if ($urandom_range(0, 5) == 0) r.rh = 16'($urandom);
    if ($urandom_range(0, 12) == 0) r.rt = OFF_MARK_TP;
    if ($urandom_range(0, 12) == 0) r.rp = OFF_MARK_TP;
    if ($urandom_range(0, 12) == 0) r.rh = OFF_MARK_H;
    return r;
  endfunction

  task automatic run_random(input int n);
    for (int i = 0; i < n; i++) pending_readings.push_back(rnd_reading());
    wait_idle();
  endtask

  // typical calibration words
  localparam logic [47:0] TYP_T  = {16'hFC18, 16'd26435, 16'd27504};
  localparam logic [47:0] TYP_PA = {16'd3024, -16'sd10685, 16'd36477};
  localparam logic [47:0] TYP_PB = {-16'sd7, 16'd140, 16'd2855};
  localparam logic [47:0] TYP_PC = {16'd6000, -16'sd14600, 16'd15500};
  localparam logic [47:0] TYP_HA = {8'd0, 8'd30, 8'd0, 16'd362, 8'd75};
  localparam logic [47:0] TYP_HB = {24'd0, 12'd50, 12'd313};

  initial begin
    cal_t = '0; cal_pa = '0; cal_pb = '0; cal_pc = '0;
    cal_ha = '0; cal_hb = '0; cal_ofs = 0; fine_t = 0;
    cfg_chan.valid = 1'b0;
    cfg_chan.index = CFG_TEMP;
    cfg_chan.data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: every divisor is zero
    pending_readings.push_back({24'h654320, 24'h500000, 16'h6000});
    pending_readings.push_back({24'h000000, 24'h000000, 16'h0000});
    wait_idle();

    // directed items on typical calibration
    load_calib(TYP_T, TYP_PA, TYP_PB, TYP_PC, TYP_HA, TYP_HB, 48'd0);
    write_reg(CFG_UNUSED, '1);
    pending_readings.push_back({24'h7E9F00, 24'h5A4B30, 16'h6B2C});
    pending_readings.push_back({24'h000000, 24'h000000, 16'h0000});
    pending_readings.push_back({24'hFFFFFF, 24'hFFFFFF, 16'hFFFF});
    pending_readings.push_back({OFF_MARK_TP, 24'h5A4B30, 16'h6B2C});
    pending_readings.push_back({24'h7E9F00, OFF_MARK_TP, 16'h6B2C});
    pending_readings.push_back({24'h7E9F00, 24'h5A4B30, OFF_MARK_H});
    pending_readings.push_back({OFF_MARK_TP, OFF_MARK_TP, OFF_MARK_H});
    pending_readings.push_back({24'h800001, 24'h7FFFFF, 16'h7FFF});
    pending_readings.push_back({24'h7FFFFF, 24'h800001, 16'h8001});
    pending_readings.push_back({24'h7E9F00, 24'h000010, 16'hFFFF});
    pending_readings.push_back({24'h7E9F00, 24'hFFFFF0, 16'h0000});
    wait_idle();

    // extreme offsets on fine temperature
    write_reg(CFG_OFS, {16'h0, 32'h7FFFFFFF});
    pending_readings.push_back({24'h7E9F00, 24'h5A4B30, 16'h6B2C});
    pending_readings.push_back({OFF_MARK_TP, 24'h5A4B30, 16'h6B2C});
    wait_idle();
    write_reg(CFG_OFS, {16'h0, 32'h80000000});
    pending_readings.push_back({24'h7E9F00, 24'h5A4B30, 16'h6B2C});
    pending_readings.push_back({24'h000000, 24'hFFFFFF, 16'hFFFF});
    wait_idle();

    // zero divisor with pressure enabled
    write_reg(CFG_OFS, 48'd0);
    write_reg(CFG_PA, {TYP_PA[47:16], 16'd0});
    pending_readings.push_back({24'h7E9F00, 24'h5A4B30, 16'h6B2C});
    pending_readings.push_back({24'h7E9F00, OFF_MARK_TP, 16'h6B2C});
    wait_idle();

    // random phases over typical, extreme and random calibrations
    load_calib(TYP_T, TYP_PA, TYP_PB, TYP_PC, TYP_HA, TYP_HB, 48'd0);
    run_random(300);
    load_calib('1, '1, '1, '1, '1, '1, '1);
    run_random(100);
    load_calib({16'h7FFF, 16'h7FFF, 16'hFFFF}, {16'h7FFF, 16'h7FFF, 16'hFFFF},
               {16'h7FFF, 16'h7FFF, 16'h7FFF}, {16'h7FFF, 16'h7FFF, 16'h7FFF},
               {8'h00, 8'h7F, 8'hFF, 16'h7FFF, 8'hFF}, {24'h0, 12'h7FF, 12'h7FF},
               48'd0);
    run_random(100);
    load_calib({16'h8000, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h0001},
               {16'h8000, 16'h8000, 16'h8000}, {16'h8000, 16'h8000, 16'h8000},
               {8'h00, 8'h80, 8'h00, 16'h8000, 8'h00}, {24'h0, 12'h800, 12'h800},
               48'd0);
    run_random(100);
    for (int k = 0; k < 3; k++) begin
      load_calib(rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48(), rnd48());
      run_random(100);
    end
    load_calib(TYP_T ^ {32'h0, 16'($urandom_range(0, 16'hFFF))}, TYP_PA, TYP_PB,
               TYP_PC, TYP_HA, TYP_HB,
               {16'h0, 32'($urandom_range(0, 20000)) - 32'd10000});
    run_random(130);

    // final stretch with no idling
    calm = 1;
    run_random(120);

    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
design/esc_pkg.sv
design/esc_in_if.sv
design/esc_out_if.sv
design/esc_cfg_if.sv
design/env_sensor_compensation.sv
tb/sv/tb_env_sensor_compensation.sv
